### src/kiss_rng_pkg.sv
// ----------------------------------------------------------------------------
// KISS random generator package
// Shared constants, codes and state types of the KISS random generator.
// ----------------------------------------------------------------------------
`default_nettype none

package kiss_rng_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ModW  = 31;
  localparam int unsigned ModeW = 2;
  localparam int unsigned IdxW  = 2;

  // Default seeds, also the reset state
  localparam logic [WordW-1:0] DefLcg   = 32'h2011_1958;
  localparam logic [WordW-1:0] DefXor   = 32'h1108_1965;
  localparam logic [WordW-1:0] DefMwc   = 32'h0109_1988;
  localparam logic [WordW-1:0] DefCarry = 32'h1211_1957;

  // Generator coefficients
  localparam logic [WordW-1:0] LcgMul = 32'h1112_1989;
  localparam logic [WordW-1:0] LcgAdd = 32'h2004_1991;
  localparam logic [WordW-1:0] MwcMul = 32'd698769069;

  // Xorshift amounts
  localparam int unsigned XsA = 13;
  localparam int unsigned XsB = 17;
  localparam int unsigned XsC = 5;

  // Request kinds carried on tuser
  typedef enum logic [ModeW-1:0] {
    MODE_DRAW    = 2'd0,
    MODE_RESTORE = 2'd1,
    MODE_LOAD    = 2'd2
  } mode_e;

  // Configuration register indexes
  typedef enum logic [IdxW-1:0] {
    CFG_SEED_LCG = 2'd0,
    CFG_SEED_XOR = 2'd1,
    CFG_SEED_MWC = 2'd2
  } cfg_idx_e;

  // Draw sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LCG,
    ST_MUL_MWC,
    ST_MWC_UPD,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

### src/kiss_random_generator.sv
// ----------------------------------------------------------------------------
// KISS random generator
// Congruential, xorshift and multiply-with-carry parts summed per draw, with
// an optional remainder by a run-time modulus.
// ----------------------------------------------------------------------------
// A draw request (tuser = 0) occupies the block from acceptance until its
// value is handed to the output register; when max_value is nonzero the 32
// steps of the bit-serial remainder unit follow the generator update, which
// goes through one shared 32x32 multiplier in two passes. Restore (tuser = 1)
// and load (tuser = 2) requests are applied on acceptance and return nothing;
// tuser = 3 is dropped. A finished value waits in the output register, so the
// next request is taken while the previous one is still unread. Seeds written
// through the configuration port take effect on the next load request; a zero
// seed selects the default of that word.
`default_nettype none

module kiss_random_generator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  // request stream
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // [30:0] max_value, [31] zero
  input  wire logic [1:0]  s_axis_tuser_i,  // [1:0] mode
  // result stream
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [31:0] m_axis_tdata_o   // [31:0] value
);

  localparam int unsigned W  = kiss_rng_pkg::WordW;
  localparam int unsigned MW = kiss_rng_pkg::ModW;
  localparam int unsigned CntW = $clog2(W);

  kiss_rng_pkg::state_e state_q, state_d;

  logic [W-1:0]    seed_lcg_q, seed_xor_q, seed_mwc_q;
  logic [W-1:0]    lcg_q, lcg_d, xor_q, xor_d, mwc_q, mwc_d, carry_q, carry_d;
  logic [2*W-1:0]  prod_q, prod_d;
  logic [MW-1:0]   mod_q, mod_d;
  logic [W-1:0]    dvd_q, dvd_d;
  logic [MW-1:0]   rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic [W-1:0]    out_q;
  logic [W-1:0]    res_q, res_d;

  // shared multiplier operands
  logic [W-1:0]    mul_a, mul_b;
  // combinational helpers
  logic [W-1:0]    xs1, xs2, xs3;
  logic [2*W-1:0]  mwc_t;
  logic [W-1:0]    sum, mag;
  logic [W-1:0]    trial;
  logic            fits;
  logic            in_acc;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == kiss_rng_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // Share one multiplier between the congruential and carry steps
  assign mul_a  = (state_q == kiss_rng_pkg::ST_MUL_LCG) ? kiss_rng_pkg::LcgMul
                                                        : kiss_rng_pkg::MwcMul;
  assign mul_b  = (state_q == kiss_rng_pkg::ST_MUL_LCG) ? lcg_q : mwc_q;
  assign prod_d = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};

  // Xorshift step with logical shifts
  assign xs1 = xor_q ^ (xor_q << kiss_rng_pkg::XsA);
  assign xs2 = xs1 ^ (xs1 >> kiss_rng_pkg::XsB);
  assign xs3 = xs2 ^ (xs2 << kiss_rng_pkg::XsC);

  // Multiply-with-carry sum at full width
  assign mwc_t = prod_q + {{W{1'b0}}, carry_q};

  // Signed sum and its magnitude
  assign sum = lcg_q + xor_q + mwc_q;
  assign mag = sum[W-1] ? (~sum + W'(1)) : sum;

  // Restoring remainder step
  assign trial = {rem_q, dvd_q[W-1]};
  assign fits  = (trial >= {1'b0, mod_q});

  // Sequencer and datapath next values
  always_comb begin
    state_d     = state_q;
    lcg_d       = lcg_q;
    xor_d       = xor_q;
    mwc_d       = mwc_q;
    carry_d     = carry_q;
    mod_d       = mod_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;

    // drop the result once taken
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      kiss_rng_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (s_axis_tuser_i)
            kiss_rng_pkg::MODE_DRAW: begin
              mod_d   = s_axis_tdata_i[MW-1:0];
              state_d = kiss_rng_pkg::ST_MUL_LCG;
            end
            kiss_rng_pkg::MODE_RESTORE: begin
              lcg_d   = kiss_rng_pkg::DefLcg;
              xor_d   = kiss_rng_pkg::DefXor;
              mwc_d   = kiss_rng_pkg::DefMwc;
              carry_d = kiss_rng_pkg::DefCarry;
            end
            kiss_rng_pkg::MODE_LOAD: begin
              lcg_d   = (seed_lcg_q != '0) ? seed_lcg_q : kiss_rng_pkg::DefLcg;
              xor_d   = (seed_xor_q != '0) ? seed_xor_q : kiss_rng_pkg::DefXor;
              mwc_d   = (seed_mwc_q != '0) ? seed_mwc_q : kiss_rng_pkg::DefMwc;
              carry_d = kiss_rng_pkg::DefCarry;
            end
            default: begin
            end
          endcase
        end
      end
      kiss_rng_pkg::ST_MUL_LCG: begin
        state_d = kiss_rng_pkg::ST_MUL_MWC;
      end
      kiss_rng_pkg::ST_MUL_MWC: begin
        // congruential product is ready; advance xorshift alongside
        lcg_d   = prod_q[W-1:0] + kiss_rng_pkg::LcgAdd;
        xor_d   = xs3;
        state_d = kiss_rng_pkg::ST_MWC_UPD;
      end
      kiss_rng_pkg::ST_MWC_UPD: begin
        mwc_d   = mwc_t[W-1:0];
        carry_d = mwc_t[2*W-1:W];
        state_d = kiss_rng_pkg::ST_SUM;
      end
      kiss_rng_pkg::ST_SUM: begin
        dvd_d = mag;
        rem_d = '0;
        cnt_d = '0;
        if (mod_q == '0) begin
          rem_d   = '0;
          res_d   = mag;
          state_d = kiss_rng_pkg::ST_DONE;
        end else begin
          state_d = kiss_rng_pkg::ST_DIV;
        end
      end
      kiss_rng_pkg::ST_DIV: begin
        rem_d = fits ? MW'(trial - {1'b0, mod_q}) : trial[MW-1:0];
        dvd_d = {dvd_q[W-2:0], 1'b0};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(W - 1)) begin
          res_d   = {{(W-MW){1'b0}}, rem_d};
          state_d = kiss_rng_pkg::ST_DONE;
        end
      end
      kiss_rng_pkg::ST_DONE: begin
        // hand the value over once the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          state_d     = kiss_rng_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kiss_rng_pkg::ST_IDLE;
      end
    endcase
  end

  // Control, generator and seed registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kiss_rng_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      lcg_q       <= kiss_rng_pkg::DefLcg;
      xor_q       <= kiss_rng_pkg::DefXor;
      mwc_q       <= kiss_rng_pkg::DefMwc;
      carry_q     <= kiss_rng_pkg::DefCarry;
      seed_lcg_q  <= '0;
      seed_xor_q  <= '0;
      seed_mwc_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      lcg_q       <= lcg_d;
      xor_q       <= xor_d;
      mwc_q       <= mwc_d;
      carry_q     <= carry_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kiss_rng_pkg::CFG_SEED_LCG: seed_lcg_q <= cfg_data_i;
          kiss_rng_pkg::CFG_SEED_XOR: seed_xor_q <= cfg_data_i;
          kiss_rng_pkg::CFG_SEED_MWC: seed_mwc_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers; the finished value moves to the output on handoff
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    mod_q  <= mod_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    if (state_q == kiss_rng_pkg::ST_DONE) begin
      if (!out_valid_q || m_axis_tready_i) begin
        out_q <= res_q;
      end
    end
  end

`ifndef SYNTHESIS
  // A draw request starts the multiplier pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser_i == kiss_rng_pkg::MODE_DRAW)
      |=> (state_q == kiss_rng_pkg::ST_MUL_LCG))
    else $error("draw request did not start the sequencer");

  // Partial remainder stays below the modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kiss_rng_pkg::ST_DIV) |-> (rem_q < mod_q))
    else $error("partial remainder out of range");

  // Last divider step leads to the handoff state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kiss_rng_pkg::ST_DIV && cnt_q == CntW'(W - 1))
      |=> (state_q == kiss_rng_pkg::ST_DONE))
    else $error("divider overran its step count");

  // A delivered value never exceeds two to the 31
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o <= 32'h8000_0000))
    else $error("result magnitude out of range");

  // A new value is loaded only into a free or draining output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kiss_rng_pkg::ST_DONE && out_valid_q && !m_axis_tready_i)
      |=> (state_q == kiss_rng_pkg::ST_DONE))
    else $error("result overwritten while unread");
`endif

endmodule

`default_nettype wire

### bench/kiss_random_generator_tb.sv
// ----------------------------------------------------------------------------
// KISS random generator testbench
// Sends draw, restore, load and unused requests on the request stream and
// checks every returned value against a predictor of the three generator
// parts. Seeds are reprogrammed between phases while the block is idle. The
// run includes random gaps on both sides, a long hold-off on the result side
// and a forced smallest sum.
// ----------------------------------------------------------------------------

module kiss_random_generator_tb;

  localparam logic [kiss_rng_pkg::ModeW-1:0] ModeUnused = 2'd3;
  localparam int unsigned SettleCycles = 48;
  localparam int unsigned PhaseItems   = 240;
  localparam int unsigned HoldAt       = 4000;
  localparam int unsigned HoldLen      = 600;
  localparam int unsigned QuietFrom    = 20000;
  localparam int unsigned QuietTo      = 35000;

  typedef struct packed {
    logic [kiss_rng_pkg::ModeW-1:0] mode;
    logic [kiss_rng_pkg::ModW-1:0]  max_value;
  } request_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;

  // Predicted generator state and seed registers
  logic [kiss_rng_pkg::WordW-1:0] gen_lcg = kiss_rng_pkg::DefLcg;
  logic [kiss_rng_pkg::WordW-1:0] gen_xor = kiss_rng_pkg::DefXor;
  logic [kiss_rng_pkg::WordW-1:0] gen_mwc = kiss_rng_pkg::DefMwc;
  logic [kiss_rng_pkg::WordW-1:0] gen_carry = kiss_rng_pkg::DefCarry;
  logic [kiss_rng_pkg::WordW-1:0] seed_lcg = '0;
  logic [kiss_rng_pkg::WordW-1:0] seed_xor = '0;
  logic [kiss_rng_pkg::WordW-1:0] seed_mwc = '0;

  request_t                       pending_requests[$];
  logic [kiss_rng_pkg::WordW-1:0] draws_expected[$];
  int unsigned      cycle_no = 0;
  int unsigned      hold_left = 0;
  int unsigned      failures = 0;
  bit               req_fire = 1'b0;
  bit               res_fire = 1'b0;

  kiss_random_generator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),  // [30:0] max_value, [31] zero
    .s_axis_tuser_i (s_axis_tuser_i),  // [1:0] mode
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)   // [31:0] value
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [kiss_rng_pkg::WordW-1:0] lcg_next(
      logic [kiss_rng_pkg::WordW-1:0] x);
    return kiss_rng_pkg::LcgMul * x + kiss_rng_pkg::LcgAdd;
  endfunction

  function automatic logic [kiss_rng_pkg::WordW-1:0] xorshift_next(
      logic [kiss_rng_pkg::WordW-1:0] y);
    y = y ^ (y << kiss_rng_pkg::XsA);
    y = y ^ (y >> kiss_rng_pkg::XsB);
    y = y ^ (y << kiss_rng_pkg::XsC);
    return y;
  endfunction

  // Advance the predicted generator for one accepted request
  function automatic void predict_request(logic [kiss_rng_pkg::ModeW-1:0] mode,
                                          logic [kiss_rng_pkg::ModW-1:0]  max_value);
    logic [63:0]                    product;
    logic [kiss_rng_pkg::WordW-1:0] sum;
    logic [kiss_rng_pkg::WordW-1:0] magnitude;
    case (mode)
      kiss_rng_pkg::MODE_DRAW: begin
        gen_lcg   = lcg_next(gen_lcg);
        gen_xor   = xorshift_next(gen_xor);
        product   = 64'(kiss_rng_pkg::MwcMul) * 64'(gen_mwc) + 64'(gen_carry);
        gen_carry = product[63:32];
        gen_mwc   = product[31:0];
        sum       = gen_lcg + gen_xor + gen_mwc;
        magnitude = sum[31] ? (32'd0 - sum) : sum;
        if (max_value != '0) magnitude = magnitude % {1'b0, max_value};
        draws_expected.push_back(magnitude);
      end
      kiss_rng_pkg::MODE_RESTORE: begin
        gen_lcg   = kiss_rng_pkg::DefLcg;
        gen_xor   = kiss_rng_pkg::DefXor;
        gen_mwc   = kiss_rng_pkg::DefMwc;
        gen_carry = kiss_rng_pkg::DefCarry;
      end
      kiss_rng_pkg::MODE_LOAD: begin
        gen_lcg   = (seed_lcg != '0) ? seed_lcg : kiss_rng_pkg::DefLcg;
        gen_xor   = (seed_xor != '0) ? seed_xor : kiss_rng_pkg::DefXor;
        gen_mwc   = (seed_mwc != '0) ? seed_mwc : kiss_rng_pkg::DefMwc;
        gen_carry = kiss_rng_pkg::DefCarry;
      end
      default: ;
    endcase
  endfunction

  // Random gap decision shared by both sides, off during the quiet window
  function automatic bit take_gap();
    if (cycle_no >= QuietFrom && cycle_no < QuietTo) return 1'b0;
    return $urandom_range(0, 99) < 15;
  endfunction

  function automatic request_t random_request();
    request_t    req;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80)      req.mode = kiss_rng_pkg::MODE_DRAW;
    else if (pick < 88) req.mode = kiss_rng_pkg::MODE_RESTORE;
    else if (pick < 95) req.mode = kiss_rng_pkg::MODE_LOAD;
    else                req.mode = ModeUnused;
    case ($urandom_range(0, 9))
      0, 1:    req.max_value = '0;
      2, 3:    req.max_value = kiss_rng_pkg::ModW'($urandom_range(1, 16));
      4:       req.max_value = '1;
      5:       req.max_value = kiss_rng_pkg::ModW'(1)
                               << $urandom_range(0, kiss_rng_pkg::ModW - 1);
      default: req.max_value = kiss_rng_pkg::ModW'($urandom());
    endcase
    return req;
  endfunction

  task automatic queue_request(logic [kiss_rng_pkg::ModeW-1:0] mode,
                               logic [kiss_rng_pkg::ModW-1:0]  max_value);
    request_t req;
    req.mode      = mode;
    req.max_value = max_value;
    pending_requests.push_back(req);
  endtask

  // Write one seed register; only called while the block is idle
  task automatic write_seed(kiss_rng_pkg::cfg_idx_e idx,
                            logic [kiss_rng_pkg::WordW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      kiss_rng_pkg::CFG_SEED_LCG: seed_lcg = value;
      kiss_rng_pkg::CFG_SEED_XOR: seed_xor = value;
      kiss_rng_pkg::CFG_SEED_MWC: seed_mwc = value;
      default: ;
    endcase
  endtask

  task automatic write_seeds(logic [kiss_rng_pkg::WordW-1:0] s_lcg,
                             logic [kiss_rng_pkg::WordW-1:0] s_xor,
                             logic [kiss_rng_pkg::WordW-1:0] s_mwc);
    write_seed(kiss_rng_pkg::CFG_SEED_LCG, s_lcg);
    write_seed(kiss_rng_pkg::CFG_SEED_XOR, s_xor);
    write_seed(kiss_rng_pkg::CFG_SEED_MWC, s_mwc);
  endtask

  // Wait until every request is sent and every value returned, then settle
  task automatic wait_idle();
    while (pending_requests.size() != 0 || s_axis_tvalid_i || draws_expected.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Request driver: present the next pending request or idle
  always @(negedge clk_i) begin
    request_t req;
    if (rst_ni && (!s_axis_tvalid_i || req_fire)) begin
      if (pending_requests.size() != 0 && !take_gap()) begin
        req = pending_requests.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {1'b0, req.max_value};
        s_axis_tuser_i  <= req.mode;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Result ready: random gaps plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (cycle_no == HoldAt) begin
      hold_left       <= HoldLen;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= rst_ni && !take_gap();
    end
  end

  // Monitor: check returned values, then predict accepted requests
  always @(posedge clk_i) begin
    logic [kiss_rng_pkg::WordW-1:0] expected_value;
    cycle_no = cycle_no + 1;
    req_fire = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    res_fire = rst_ni && m_axis_tvalid_o && m_axis_tready_i;
    if (res_fire) begin
      if (draws_expected.size() == 0) begin
        $error("value: no value expected, actual %h", m_axis_tdata_o);
        failures++;
      end else begin
        expected_value = draws_expected.pop_front();
        if (m_axis_tdata_o !== expected_value) begin
          $error("value: expected %h, actual %h", expected_value, m_axis_tdata_o);
          failures++;
        end
      end
    end
    if (req_fire) predict_request(s_axis_tuser_i, s_axis_tdata_i[kiss_rng_pkg::ModW-1:0]);
  end

  initial begin
    #(10 * 1_000_000);
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    logic [kiss_rng_pkg::WordW-1:0] inv_mul;
    logic [kiss_rng_pkg::WordW-1:0] s_lcg;
    logic [kiss_rng_pkg::WordW-1:0] s_xor;
    logic [kiss_rng_pkg::WordW-1:0] s_mwc;
    logic [kiss_rng_pkg::WordW-1:0] target;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Field extremes, every mode, the unused mode, default seeds
    queue_request(kiss_rng_pkg::MODE_DRAW, '0);
    queue_request(kiss_rng_pkg::MODE_DRAW, 31'd1);
    queue_request(kiss_rng_pkg::MODE_DRAW, '1);
    queue_request(kiss_rng_pkg::MODE_DRAW, 31'd2);
    queue_request(kiss_rng_pkg::MODE_DRAW, 31'h4000_0000);
    queue_request(kiss_rng_pkg::MODE_DRAW, 31'h5555_5555);
    queue_request(kiss_rng_pkg::MODE_DRAW, 31'h2AAA_AAAA);
    queue_request(ModeUnused, '1);
    queue_request(kiss_rng_pkg::MODE_DRAW, '0);
    queue_request(kiss_rng_pkg::MODE_RESTORE, 31'h1234_5678);
    queue_request(kiss_rng_pkg::MODE_DRAW, '0);
    queue_request(kiss_rng_pkg::MODE_LOAD, '1);
    queue_request(kiss_rng_pkg::MODE_DRAW, '0);
    wait_idle();

    // Force the smallest sum: solve the carry-multiply seed for a sum of -2^31
    inv_mul = kiss_rng_pkg::MwcMul;
    repeat (5) inv_mul = inv_mul * (32'd2 - kiss_rng_pkg::MwcMul * inv_mul);
    do begin
      s_lcg  = $urandom() | 32'd1;
      s_xor  = $urandom() | 32'd1;
      target = 32'h8000_0000 - lcg_next(s_lcg) - xorshift_next(s_xor);
      s_mwc  = (target - kiss_rng_pkg::DefCarry) * inv_mul;
    end while (s_mwc == '0);
    write_seeds(s_lcg, s_xor, s_mwc);
    queue_request(kiss_rng_pkg::MODE_LOAD, '0);
    queue_request(kiss_rng_pkg::MODE_DRAW, '0);
    queue_request(kiss_rng_pkg::MODE_LOAD, '0);
    queue_request(kiss_rng_pkg::MODE_DRAW, '1);
    queue_request(kiss_rng_pkg::MODE_LOAD, '0);
    queue_request(kiss_rng_pkg::MODE_DRAW, 31'd3);
    queue_request(kiss_rng_pkg::MODE_RESTORE, '0);
    queue_request(kiss_rng_pkg::MODE_DRAW, '0);
    wait_idle();

    // Random phases, each under its own seed setting
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       write_seeds('0, '0, '0);
        1:       write_seeds('1, '1, '1);
        2:       write_seeds(32'd1, 32'd1, 32'd1);
        3:       write_seeds($urandom(), $urandom(), '0);
        4:       write_seeds(32'h8000_0000, '0, 32'h8000_0000);
        default: write_seeds($urandom(), $urandom(), $urandom());
      endcase
      queue_request(kiss_rng_pkg::MODE_LOAD, kiss_rng_pkg::ModW'($urandom()));
      repeat (PhaseItems) pending_requests.push_back(random_request());
      wait_idle();
    end

    if (draws_expected.size() != 0) begin
      $error("value: %0d expected values never returned", draws_expected.size());
      failures++;
    end
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
